// File: design/lir_pkg.sv
// Shared constants, register codes and transfer types of the linear interpolation resampler.
package lir_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int MAX_STRETCH  = 8;
	localparam int SAMPLE_BITS  = 16;
	localparam int FRAC_BITS    = 32;
	localparam int RESULT_LIMIT = 64;

	localparam int CH_W    = $clog2(MAX_CHANNELS);
	localparam int COUNT_W = 4;
	localparam int WHOLE_W = 4;
	localparam int SKIP_W  = 5;
	localparam int N_W     = $clog2(RESULT_LIMIT + 1);
	localparam int ADDR_W  = 4;

	localparam int PROD_W = SAMPLE_BITS + 1 + FRAC_BITS + 1;
	localparam int ACC_W  = PROD_W + 1;

	localparam logic [FRAC_BITS-1:0] STEP_LEAST =
		FRAC_BITS'((64'd1 << FRAC_BITS) / MAX_STRETCH);

	localparam logic [WHOLE_W-1:0]   RST_STEP_WHOLE    = WHOLE_W'(1);
	localparam logic [FRAC_BITS-1:0] RST_STEP_FRACTION = '0;
	localparam logic [COUNT_W-1:0]   RST_CHANNEL_COUNT = COUNT_W'(1);
	localparam logic                 RST_PASS_THROUGH  = 1'b1;

	typedef enum logic [1:0] {
		REG_STEP_WHOLE    = 2'd0,
		REG_STEP_FRACTION = 2'd1,
		REG_CHANNEL_COUNT = 2'd2,
		REG_PASS_THROUGH  = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          end_of_stream;
	} src_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic [CH_W-1:0]               channel_out;
		logic                          last_of_run;
	} dst_item_t;

endpackage

// File: design/linear_interp_resampler_top.sv
// Linear interpolation resampler: APB registers, frame store and shared multiply sequencer.
// A pass-through sample is registered and shows in the cycle after its input transfer; ready
//   returns once the sequencer has passed through ST_FIN after the last output transfer. One item at a time.
// Interpolation: each output goes through multiply, round and transfer (ST_MUL, ST_RND, ST_EMIT) on the one
//   shared multiplier; the transfer waits in ST_EMIT while dst_ready is low.
// A pass-through item goes through ST_EMIT and then ST_FIN; an item that causes no result goes straight to ST_FIN.
// Reset (arst_n low): step 1.0, one channel, pass-through on; frames, position, skip, cursor cleared.
module linear_interp_resampler_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             src_valid,
	output logic                             src_ready,
	input  lir_pkg::src_item_t               src_data,
	output logic                             dst_valid,
	input  logic                             dst_ready,
	output lir_pkg::dst_item_t               dst_data,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lir_pkg::ADDR_W-1:0]       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RND,
		ST_EMIT,
		ST_FIN
	} state_t;

	// Configuration registers
	logic [lir_pkg::WHOLE_W-1:0]   step_whole_q;
	logic [lir_pkg::FRAC_BITS-1:0] step_fraction_q;
	logic [lir_pkg::COUNT_W-1:0]   channel_count_q;
	logic                          pass_through_q;

	// Stream state
	logic signed [lir_pkg::SAMPLE_BITS-1:0] prev_q [lir_pkg::MAX_CHANNELS];
	logic signed [lir_pkg::SAMPLE_BITS-1:0] cur_q  [lir_pkg::MAX_CHANNELS];
	logic [lir_pkg::FRAC_BITS-1:0] pos_q;
	logic [lir_pkg::SKIP_W-1:0]    skip_q;
	logic [lir_pkg::CH_W-1:0]      cursor_q;
	logic                          have_prev_q;

	// Per-item sequencer state
	state_t                        state_q;
	logic                          eos_q;
	logic                          done_q;
	logic                          dec_q;
	logic                          pt_q;
	logic [lir_pkg::CH_W-1:0]      c_q;
	logic [lir_pkg::N_W-1:0]       n_q;
	logic signed [lir_pkg::PROD_W-1:0] prod_q;
	lir_pkg::dst_item_t            out_q;
	logic                          out_valid_q;

	logic                          cfg_wr;
	logic [1:0]                    cfg_idx;
	logic [lir_pkg::COUNT_W-1:0]   eff_chans;
	logic                          frame_done;
	logic                          src_xfer;
	logic                          last_ch;
	logic [lir_pkg::FRAC_BITS:0]   f_next;
	logic [lir_pkg::SKIP_W-1:0]    adv;
	logic                          over_limit;
	logic                          brk;
	logic signed [lir_pkg::SAMPLE_BITS:0]   diff;
	logic signed [lir_pkg::FRAC_BITS:0]     f_sgn;
	logic signed [lir_pkg::PROD_W-1:0]      prod_d;
	logic signed [lir_pkg::ACC_W-1:0]       acc;
	logic [lir_pkg::SAMPLE_BITS-1:0]        rounded;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[3:2];

	// Register file; the step is held at 1/MAX_STRETCH or more whenever its whole part is zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_whole_q    <= lir_pkg::RST_STEP_WHOLE;
			step_fraction_q <= lir_pkg::RST_STEP_FRACTION;
			channel_count_q <= lir_pkg::RST_CHANNEL_COUNT;
			pass_through_q  <= lir_pkg::RST_PASS_THROUGH;
		end else if (cfg_wr) begin
			case (cfg_idx)
				lir_pkg::REG_STEP_WHOLE: begin
					step_whole_q <= pwdata[lir_pkg::WHOLE_W-1:0];
					if (pwdata[lir_pkg::WHOLE_W-1:0] == '0 &&
					    step_fraction_q < lir_pkg::STEP_LEAST) begin
						step_fraction_q <= lir_pkg::STEP_LEAST;
					end
				end
				lir_pkg::REG_STEP_FRACTION: begin
					if (step_whole_q == '0 &&
					    pwdata[lir_pkg::FRAC_BITS-1:0] < lir_pkg::STEP_LEAST) begin
						step_fraction_q <= lir_pkg::STEP_LEAST;
					end else begin
						step_fraction_q <= pwdata[lir_pkg::FRAC_BITS-1:0];
					end
				end
				lir_pkg::REG_CHANNEL_COUNT: begin
					channel_count_q <= pwdata[lir_pkg::COUNT_W-1:0];
				end
				lir_pkg::REG_PASS_THROUGH: begin
					pass_through_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			lir_pkg::REG_STEP_WHOLE:    prdata = 32'(step_whole_q);
			lir_pkg::REG_STEP_FRACTION: prdata = 32'(step_fraction_q);
			lir_pkg::REG_CHANNEL_COUNT: prdata = 32'(channel_count_q);
			lir_pkg::REG_PASS_THROUGH:  prdata = 32'(pass_through_q);
			default:                    prdata = '0;
		endcase
	end

	// A count of zero runs one channel; anything above the maximum runs the maximum
	always_comb begin
		if (channel_count_q == '0) begin
			eff_chans = lir_pkg::COUNT_W'(1);
		end else if (channel_count_q > lir_pkg::COUNT_W'(lir_pkg::MAX_CHANNELS)) begin
			eff_chans = lir_pkg::COUNT_W'(lir_pkg::MAX_CHANNELS);
		end else begin
			eff_chans = channel_count_q;
		end
	end

	assign src_ready  = (state_q == ST_IDLE);
	assign src_xfer   = src_valid & src_ready;
	// Frame closes when the cursor reaches or passes the last active channel
	assign frame_done = ({1'b0, cursor_q} + lir_pkg::COUNT_W'(1)) >= eff_chans;

	// Position bookkeeping for the end of one output position
	assign last_ch    = ({1'b0, c_q} + lir_pkg::COUNT_W'(1)) == eff_chans;
	assign f_next     = {1'b0, pos_q} + {1'b0, step_fraction_q};
	assign adv        = lir_pkg::SKIP_W'(step_whole_q) +
	                    lir_pkg::SKIP_W'(f_next[lir_pkg::FRAC_BITS]);
	assign over_limit = (8'(n_q) + 8'd1 + 8'(eff_chans)) > 8'(lir_pkg::RESULT_LIMIT);
	assign brk        = (adv != '0) || over_limit;

	// Shared multiplier: prev*(1-f) + cur*f is rewritten as prev + (cur-prev)*f
	assign diff   = (lir_pkg::SAMPLE_BITS+1)'(cur_q[c_q]) -
	                (lir_pkg::SAMPLE_BITS+1)'(prev_q[c_q]);
	assign f_sgn  = $signed({1'b0, pos_q});
	assign prod_d = diff * f_sgn;

	// Sum and truncate toward zero: floor, then add one for a negative value with a remainder
	assign acc = $signed({{(lir_pkg::ACC_W-lir_pkg::SAMPLE_BITS-lir_pkg::FRAC_BITS)
	                       {prev_q[c_q][lir_pkg::SAMPLE_BITS-1]}},
	                      prev_q[c_q], {lir_pkg::FRAC_BITS{1'b0}}}) +
	             $signed({{(lir_pkg::ACC_W-lir_pkg::PROD_W){prod_q[lir_pkg::PROD_W-1]}},
	                      prod_q});
	assign rounded = acc[lir_pkg::FRAC_BITS +: lir_pkg::SAMPLE_BITS] +
	                 lir_pkg::SAMPLE_BITS'(acc[lir_pkg::ACC_W-1] &&
	                                       (acc[lir_pkg::FRAC_BITS-1:0] != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int i = 0; i < lir_pkg::MAX_CHANNELS; i++) begin
				prev_q[i] <= '0;
				cur_q[i]  <= '0;
			end
			pos_q       <= '0;
			skip_q      <= '0;
			cursor_q    <= '0;
			have_prev_q <= 1'b0;
			eos_q       <= 1'b0;
			done_q      <= 1'b0;
			dec_q       <= 1'b0;
			pt_q        <= 1'b0;
			c_q         <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (src_xfer) begin
						cur_q[cursor_q] <= src_data.sample_in;
						eos_q  <= src_data.end_of_stream;
						done_q <= frame_done;
						dec_q  <= frame_done && !pass_through_q && have_prev_q &&
						          (skip_q != '0);
						pt_q   <= pass_through_q;
						c_q    <= '0;
						n_q    <= '0;
						if (pass_through_q) begin
							// Copy the sample straight into the output register
							out_q.sample_out  <= src_data.sample_in;
							out_q.channel_out <= cursor_q;
							out_q.last_of_run <= 1'b1;
							out_valid_q       <= 1'b1;
							state_q           <= ST_EMIT;
						end else if (frame_done && have_prev_q && skip_q == '0) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_MUL: begin
					prod_q  <= prod_d;
					state_q <= ST_RND;
				end
				ST_RND: begin
					out_q.sample_out  <= rounded;
					out_q.channel_out <= c_q;
					out_q.last_of_run <= last_ch && brk;
					out_valid_q       <= 1'b1;
					state_q           <= ST_EMIT;
				end
				ST_EMIT: begin
					if (dst_ready) begin
						out_valid_q <= 1'b0;
						if (pt_q) begin
							state_q <= ST_FIN;
						end else begin
							n_q <= n_q + lir_pkg::N_W'(1);
							if (last_ch) begin
								// Advance the position; stop once it crosses into the next frame or the result limit would be passed
								pos_q <= f_next[lir_pkg::FRAC_BITS-1:0];
								if (adv != '0) begin
									skip_q  <= adv - lir_pkg::SKIP_W'(1);
									state_q <= ST_FIN;
								end else if (over_limit) begin
									state_q <= ST_FIN;
								end else begin
									c_q     <= '0;
									state_q <= ST_MUL;
								end
							end else begin
								c_q     <= c_q + lir_pkg::CH_W'(1);
								state_q <= ST_MUL;
							end
						end
					end
				end
				ST_FIN: begin
					if (done_q) begin
						if (dec_q) begin
							skip_q <= skip_q - lir_pkg::SKIP_W'(1);
						end
						for (int i = 0; i < lir_pkg::MAX_CHANNELS; i++) begin
							prev_q[i] <= cur_q[i];
						end
						have_prev_q <= 1'b1;
						cursor_q    <= '0;
					end else begin
						cursor_q <= cursor_q + lir_pkg::CH_W'(1);
					end
					// End of stream: drop the partial frame and restart the position
					if (eos_q) begin
						pos_q       <= '0;
						skip_q      <= '0;
						cursor_q    <= '0;
						have_prev_q <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

endmodule
